>>> design/timer_interrupt_register_block_macros.svh
// ----------------------------------------------------------------------------
// timer and interrupt register block assertion macros
// concurrent checks on clk, switched off in synthesis
// ----------------------------------------------------------------------------
`ifndef TIMER_INTERRUPT_REGISTER_BLOCK_MACROS_SVH
`define TIMER_INTERRUPT_REGISTER_BLOCK_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TIRB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer_interrupt_register_block: same-cycle check failed");

// next-cycle implication
`define TIRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer_interrupt_register_block: next-cycle check failed");

`else

`define TIRB_ASSERT_SAME(label, ante, cons)
`define TIRB_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/tirb_pkg.sv
// ----------------------------------------------------------------------------
// tirb_pkg
// types, register addresses and constants of the timer and interrupt block
// ----------------------------------------------------------------------------
package tirb_pkg;

    // divider prescaler width (4 to 16)
    localparam int DIV_PRESCALE_BITS = 8;
    localparam int DIV_SUM_W = ((DIV_PRESCALE_BITS > 6) ? DIV_PRESCALE_BITS : 6) + 1;

    // register map
    localparam logic [15:0] ADDR_IE   = 16'hffff;
    localparam logic [15:0] ADDR_IF   = 16'hff0f;
    localparam logic [15:0] ADDR_DIV  = 16'hff04;
    localparam logic [15:0] ADDR_TIMA = 16'hff05;
    localparam logic [15:0] ADDR_TMA  = 16'hff06;
    localparam logic [15:0] ADDR_TAC  = 16'hff07;
    localparam logic [15:0] ADDR_BOOT = 16'hff50;

    localparam logic [5:0] HALT_CYCLES    = 6'd3;
    localparam logic [6:0] VEC_BASE       = 7'h40;
    localparam int         TAC_ENABLE_BIT = 2;
    localparam logic [4:0] FLAG_TIMER     = 5'b00100;

    typedef enum logic [2:0] {
        OP_READ    = 3'd0,
        OP_WRITE   = 3'd1,
        OP_TICK    = 3'd2,
        OP_REQUEST = 3'd3,
        OP_ENABLE  = 3'd4,
        OP_DISABLE = 3'd5,
        OP_HALT    = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        TSEL_256 = 2'd0,
        TSEL_4   = 2'd1,
        TSEL_16  = 2'd2,
        TSEL_64  = 2'd3
    } tsel_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] addr;
        logic [7:0]  write_data;
        logic [5:0]  tick_cycles;
        logic [4:0]  irq_request_mask;
    } tirb_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        bad_address;
        logic        irq_taken;
        logic [6:0]  irq_vector;
        logic        halted_now;
        logic        master_enable;
    } tirb_result_t;

    typedef struct packed {
        logic [7:0]                   enable_mask;
        logic [4:0]                   flag_bits;
        logic [7:0]                   divider_value;
        logic [DIV_PRESCALE_BITS-1:0] divider_prescale;
        logic [7:0]                   timer_count;
        logic [7:0]                   timer_reload;
        logic [2:0]                   timer_control;
        logic [7:0]                   timer_prescale;
        logic [7:0]                   boot_disable;
        logic                         ime_flag;
        logic                         halt_flag;
    } tirb_state_t;

    // timer period minus one for a clock select code
    function automatic logic [7:0] timer_mask(input logic [1:0] sel);
        logic [7:0] m;
        unique case (tsel_t'(sel))
            TSEL_4:   m = 8'd3;
            TSEL_16:  m = 8'd15;
            TSEL_64:  m = 8'd63;
            default:  m = 8'd255;
        endcase
        return m;
    endfunction

endpackage

>>> design/tirb_exec.sv
// ----------------------------------------------------------------------------
// tirb_exec
// one item against the current state: next state and result
// ----------------------------------------------------------------------------
module tirb_exec
(
    input  tirb_pkg::tirb_item_t   item,
    input  tirb_pkg::tirb_state_t  cur,
    output tirb_pkg::tirb_state_t  nxt,
    output tirb_pkg::tirb_result_t result
);

    logic [5:0]                     cyc_eff;
    logic [tirb_pkg::DIV_SUM_W-1:0] div_sum;
    logic [7:0]                     tmr_mask;
    logic [8:0]                     tmr_sum;
    logic                           tmr_step;
    logic [4:0]                     pend;
    logic [2:0]                     irq_idx;

    // lowest set bit of the pending set
    function automatic logic [2:0] lowest_bit(input logic [4:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 4; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // a halted core advances by HALT_CYCLES instead of the item's tick_cycles
    assign cyc_eff  = cur.halt_flag ? tirb_pkg::HALT_CYCLES : item.tick_cycles;
    assign div_sum  = tirb_pkg::DIV_SUM_W'(cur.divider_prescale)
                    + tirb_pkg::DIV_SUM_W'(cyc_eff);
    assign tmr_mask = tirb_pkg::timer_mask(cur.timer_control[1:0]);
    assign tmr_sum  = {1'b0, cur.timer_prescale} + {3'b000, cyc_eff};
    assign tmr_step = tmr_sum > {1'b0, tmr_mask};

    always_comb
    begin
        nxt     = cur;
        result  = '0;
        pend    = '0;
        irq_idx = '0;

        unique case (tirb_pkg::op_t'(item.op))
            tirb_pkg::OP_READ:
            begin
                unique case (item.addr)
                    tirb_pkg::ADDR_IE:   result.read_data = cur.enable_mask;
                    tirb_pkg::ADDR_IF:   result.read_data = {3'b000, cur.flag_bits};
                    tirb_pkg::ADDR_DIV:  result.read_data = cur.divider_value;
                    tirb_pkg::ADDR_TIMA: result.read_data = cur.timer_count;
                    tirb_pkg::ADDR_TMA:  result.read_data = cur.timer_reload;
                    tirb_pkg::ADDR_TAC:  result.read_data = {5'b00000, cur.timer_control};
                    tirb_pkg::ADDR_BOOT: result.read_data = cur.boot_disable;
                    default:             result.bad_address = 1'b1;
                endcase
            end
            tirb_pkg::OP_WRITE:
            begin
                unique case (item.addr)
                    tirb_pkg::ADDR_IE:   nxt.enable_mask = item.write_data;
                    tirb_pkg::ADDR_IF:   nxt.flag_bits = item.write_data[4:0];
                    tirb_pkg::ADDR_DIV:
                    begin
                        nxt.divider_value    = '0;
                        nxt.divider_prescale = '0;
                    end
                    tirb_pkg::ADDR_TIMA: nxt.timer_count = item.write_data;
                    tirb_pkg::ADDR_TMA:  nxt.timer_reload = item.write_data;
                    tirb_pkg::ADDR_TAC:  nxt.timer_control = item.write_data[2:0];
                    tirb_pkg::ADDR_BOOT: nxt.boot_disable = item.write_data;
                    default:             result.bad_address = 1'b1;
                endcase
            end
            tirb_pkg::OP_TICK:
            begin
                nxt.divider_value = cur.divider_value
                                  + 8'(div_sum >> tirb_pkg::DIV_PRESCALE_BITS);
                nxt.divider_prescale = div_sum[tirb_pkg::DIV_PRESCALE_BITS-1:0];
                if (cur.timer_control[tirb_pkg::TAC_ENABLE_BIT])
                begin
                    if (tmr_step)
                    begin
                        // overflow reloads and raises the timer flag
                        if (cur.timer_count == 8'hff)
                        begin
                            nxt.timer_count = cur.timer_reload;
                            nxt.flag_bits   = cur.flag_bits | tirb_pkg::FLAG_TIMER;
                        end
                        else
                        begin
                            nxt.timer_count = cur.timer_count + 8'd1;
                        end
                        nxt.timer_prescale = tmr_sum[7:0] & tmr_mask;
                    end
                    else
                    begin
                        nxt.timer_prescale = tmr_sum[7:0];
                    end
                end
                pend    = nxt.flag_bits & cur.enable_mask[4:0];
                irq_idx = lowest_bit(pend);
                if ((cur.ime_flag || cur.halt_flag) && (pend != 5'b00000))
                begin
                    nxt.halt_flag = 1'b0;
                    if (cur.ime_flag)
                    begin
                        nxt.ime_flag      = 1'b0;
                        nxt.flag_bits     = nxt.flag_bits & ~(5'b00001 << irq_idx);
                        result.irq_taken  = 1'b1;
                        result.irq_vector = tirb_pkg::VEC_BASE + {1'b0, irq_idx, 3'b000};
                    end
                end
            end
            tirb_pkg::OP_REQUEST: nxt.flag_bits = cur.flag_bits | item.irq_request_mask;
            tirb_pkg::OP_ENABLE:  nxt.ime_flag = 1'b1;
            tirb_pkg::OP_DISABLE: nxt.ime_flag = 1'b0;
            tirb_pkg::OP_HALT:    nxt.halt_flag = 1'b1;
            default:
            begin
                nxt = cur;
            end
        endcase

        result.halted_now    = nxt.halt_flag;
        result.master_enable = nxt.ime_flag;
    end

endmodule

>>> design/timer_interrupt_register_block.sv
// ----------------------------------------------------------------------------
// timer_interrupt_register_block
// timer, divider and interrupt controller registers with halt and dispatch
// ----------------------------------------------------------------------------
// path: input register, execute, result register
// throughput: one item per cycle, sustained while the result side keeps up
// the state is updated in the cycle an item leaves the input register
// reset (rst_n low) clears the valid bits, timer and interrupt state at once
// no clearing pass: items are taken as soon as reset is released
module timer_interrupt_register_block
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [2:0]  op,
    input  logic [15:0] addr,
    input  logic [7:0]  write_data,
    input  logic [5:0]  tick_cycles,
    input  logic [4:0]  irq_request_mask,

    // result channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [7:0]  read_data,
    output logic        bad_address,
    output logic        irq_taken,
    output logic [6:0]  irq_vector,
    output logic        halted_now,
    output logic        master_enable
);

`include "timer_interrupt_register_block_macros.svh"

    // input register stage
    logic                   a_valid_reg;
    logic                   a_valid_next;
    tirb_pkg::tirb_item_t   a_item_reg;

    // architectural state
    tirb_pkg::tirb_state_t  state_reg;
    tirb_pkg::tirb_state_t  state_next;

    // result register stage
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    tirb_pkg::tirb_result_t rsp_reg;
    tirb_pkg::tirb_result_t exec_result;

    logic                   req_fire;
    logic                   a_fire;

    // the item in the input register moves on when the result register is
    // free or is being emptied this cycle
    assign a_fire    = a_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !a_valid_reg || a_fire;
    assign req_fire  = req_valid && req_ready;

    // execute: all work for one item, between the two registers
    tirb_exec u_exec
    (
        .item   (a_item_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .result (exec_result)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (req_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_fire)
        begin
            a_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (a_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (a_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, loaded on transfer only
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            a_item_reg.op               <= op;
            a_item_reg.addr             <= addr;
            a_item_reg.write_data       <= write_data;
            a_item_reg.tick_cycles      <= tick_cycles;
            a_item_reg.irq_request_mask <= irq_request_mask;
        end
        if (a_fire)
        begin
            rsp_reg <= exec_result;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign read_data     = rsp_reg.read_data;
    assign bad_address   = rsp_reg.bad_address;
    assign irq_taken     = rsp_reg.irq_taken;
    assign irq_vector    = rsp_reg.irq_vector;
    assign halted_now    = rsp_reg.halted_now;
    assign master_enable = rsp_reg.master_enable;

    // state only moves when an item passes through execute
    `TIRB_ASSERT_NEXT(a_state_holds_when_idle, !a_fire, $stable(state_reg))
    // a dispatched interrupt leaves the core awake with the master enable off
    `TIRB_ASSERT_SAME(a_taken_clears_ime_halt, rsp_valid_reg && rsp_reg.irq_taken,
        !rsp_reg.master_enable && !rsp_reg.halted_now)
    // no vector without a dispatch
    `TIRB_ASSERT_SAME(a_vector_only_when_taken, rsp_valid_reg && !rsp_reg.irq_taken,
        rsp_reg.irq_vector == 7'd0)

endmodule
